@@ src/touch_point_and_tap_detector_unit_defines.svh @@
// Assertion macros for the touch point and tap detector.
// Each macro places one labeled concurrent assertion on its own line of use.
`ifndef TOUCH_POINT_AND_TAP_DETECTOR_UNIT_DEFINES_SVH
`define TOUCH_POINT_AND_TAP_DETECTOR_UNIT_DEFINES_SVH

`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define TPTD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tptd: property violated");
// The expression must never be true at a clock edge outside reset.
`define TPTD_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("tptd: forbidden condition seen");
`else
`define TPTD_ASSERT(lbl, clk, rst_n, prop)
`define TPTD_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ src/tptd_pkg.sv @@
package tptd_pkg;

    // Screen size in pixels.
    localparam int SCREEN_W = 480;
    localparam int SCREEN_H = 320;

    // Field widths.
    localparam int RAW_W      = 12;
    localparam int CNT_W      = 4;
    localparam int TIME_W     = 32;
    localparam int MOVE_W     = 10;
    localparam int TLIM_W     = 16;
    localparam int POS_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // A raw coordinate above this value is not a touch.
    localparam int RAW_LIMIT = 800;

    // Edge nudge thresholds on the screen X axis.
    localparam int NUDGE_LO     = 48;
    localparam int NUDGE_HI_OFS = 49;

    // Largest movement value that is kept.
    localparam int MOVE_SAT = 1023;

    // Derived widths of the mapping datapath.
    localparam int SPAN_MAX  = (SCREEN_W > SCREEN_H) ? SCREEN_W : SCREEN_H;
    localparam int SPAN_W    = $clog2(SPAN_MAX + 1);
    localparam int PROD_W    = RAW_W + SPAN_W;
    localparam int DIV_CNT_W = $clog2(PROD_W);
    localparam int MAP_W     = PROD_W + 3;
    localparam int CX_W      = $clog2(SCREEN_W);
    localparam int CY_W      = $clog2(SCREEN_H);
    localparam int DIST_W    = ((CX_W > CY_W) ? CX_W : CY_W) + 1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_X_LEFT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_RIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_TOP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_BOTTOM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT = 3'd5;

    // Register reset values.
    localparam logic [RAW_W-1:0]  RST_X_LEFT     = 12'd289;
    localparam logic [RAW_W-1:0]  RST_X_RIGHT    = 12'd8;
    localparam logic [RAW_W-1:0]  RST_Y_TOP      = 12'd10;
    localparam logic [RAW_W-1:0]  RST_Y_BOTTOM   = 12'd227;
    localparam logic [MOVE_W-1:0] RST_MOVE_LIMIT = 10'd24;
    localparam logic [TLIM_W-1:0] RST_TIME_LIMIT = 16'd700;

endpackage

@@ src/tptd_ifs.sv @@
// Sample channel.
interface tptd_in_if import tptd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              read_ok;
    logic [CNT_W-1:0]  touch_count;
    logic [RAW_W-1:0]  raw_x;
    logic [RAW_W-1:0]  raw_y;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, read_ok, touch_count, raw_x, raw_y, now_ms,
                    input ready);
    modport sink   (input valid, read_ok, touch_count, raw_x, raw_y, now_ms,
                    output ready);
endinterface

// Result channel.
interface tptd_out_if import tptd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             is_down;
    logic             tap;

    modport source (output valid, pos_x, pos_y, is_down, tap, input ready);
    modport sink   (input valid, pos_x, pos_y, is_down, tap, output ready);
endinterface

// Register write channel.
interface tptd_cfg_if import tptd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ src/touch_point_and_tap_detector_unit.sv @@
// Channel   Direction  Contents
// i_cfg     in         register index and write data
// i_in      in         read_ok, touch_count, raw_x, raw_y, now_ms
// o_out     out        pos_x, pos_y, is_down, tap
//
// A touch sample passes the multiply, divide, post and update steps; the
// bit-serial restoring dividers produce one quotient bit per cycle.
// A sample that is not a touch goes straight from request to the update step.
// Reset is synchronous; afterwards the block is idle and the registers hold
// their documented values. A stalled result holds in the output register; the
// next sample is taken meanwhile and waits in its final step until that clears.
`include "touch_point_and_tap_detector_unit_defines.svh"

module touch_point_and_tap_detector_unit import tptd_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    tptd_cfg_if.sink   i_cfg,
    tptd_in_if.sink    i_in,
    tptd_out_if.source o_out
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_POST = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;

    localparam logic signed [MAP_W-1:0] K_NUDGE_LO = MAP_W'(NUDGE_LO);
    localparam logic signed [MAP_W-1:0] K_NUDGE_HI = MAP_W'(SCREEN_W - NUDGE_HI_OFS);
    localparam logic signed [MAP_W-1:0] K_MAX_X    = MAP_W'(SCREEN_W - 1);
    localparam logic signed [MAP_W-1:0] K_MAX_Y    = MAP_W'(SCREEN_H - 1);

    // Configuration registers.
    logic [RAW_W-1:0]  r_x_left;
    logic [RAW_W-1:0]  r_x_right;
    logic [RAW_W-1:0]  r_y_top;
    logic [RAW_W-1:0]  r_y_bottom;
    logic [MOVE_W-1:0] r_move_limit;
    logic [TLIM_W-1:0] r_time_limit;

    // Sequencer and the latched sample.
    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_touch;
    logic [RAW_W-1:0]     r_raw_x;
    logic [RAW_W-1:0]     r_raw_y;
    logic [TIME_W-1:0]    r_now;

    // Divider lanes: lane 0 computes screen X from raw Y, lane 1 screen Y from raw X.
    logic [PROD_W-1:0] r_dq    [2];
    logic [RAW_W-1:0]  r_rem   [2];
    logic [RAW_W-1:0]  r_den   [2];
    logic              r_neg   [2];
    logic              r_dzero [2];

    // Mapped and clamped coordinates.
    logic [CX_W-1:0] r_sx;
    logic [CY_W-1:0] r_sy;

    // Touch tracking state.
    logic              r_active;
    logic [CX_W-1:0]   r_start_x;
    logic [CY_W-1:0]   r_start_y;
    logic [MOVE_W-1:0] r_max_move;
    logic [TIME_W-1:0] r_down_time;

    // Output register.
    logic             r_out_valid;
    logic [POS_W-1:0] r_out_x;
    logic [POS_W-1:0] r_out_y;
    logic             r_out_down;
    logic             r_out_tap;

    logic in_accept;
    logic in_touching;
    logic out_free;

    // Combinational lane signals.
    logic [RAW_W-1:0]  lane_v      [2];
    logic [RAW_W-1:0]  lane_lo     [2];
    logic [RAW_W-1:0]  lane_hi     [2];
    logic [PROD_W-1:0] lane_span   [2];
    logic [RAW_W:0]    lane_diff   [2];
    logic [RAW_W:0]    lane_dspan  [2];
    logic [RAW_W-1:0]  lane_mdiff  [2];
    logic [RAW_W-1:0]  lane_mden   [2];
    logic [PROD_W-1:0] lane_prod   [2];
    logic [RAW_W:0]    lane_trial  [2];
    logic              lane_qbit   [2];
    logic [RAW_W:0]    lane_sub    [2];
    logic signed [MAP_W-1:0] lane_q [2];

    logic signed [MAP_W-1:0] x_nudged;
    logic [CX_W-1:0]         x_clamped;
    logic [CY_W-1:0]         y_clamped;

    logic [CX_W-1:0]   dist_x;
    logic [CY_W-1:0]   dist_y;
    logic [DIST_W-1:0] dist_sum;
    logic [MOVE_W-1:0] dist_sat;
    logic [TIME_W-1:0] hold_time;
    logic              tap_ok;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_accept   = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;

    // A sample is a touch only on a good read with a finger and both
    // coordinates inside the usable raw range.
    assign in_touching = i_in.read_ok && (i_in.touch_count != '0)
                         && (i_in.raw_x <= RAW_W'(RAW_LIMIT))
                         && (i_in.raw_y <= RAW_W'(RAW_LIMIT));

    // Front end of both lanes: offset, span and product magnitudes, and the
    // sign of the quotient. The division itself runs on magnitudes so that the
    // truncation toward zero falls out of the sign-magnitude form.
    always_comb begin
        lane_v[0]    = r_raw_y;
        lane_lo[0]   = r_x_left;
        lane_hi[0]   = r_x_right;
        lane_span[0] = PROD_W'(SCREEN_W);
        lane_v[1]    = r_raw_x;
        lane_lo[1]   = r_y_top;
        lane_hi[1]   = r_y_bottom;
        lane_span[1] = PROD_W'(SCREEN_H);
        for (int l = 0; l < 2; l++) begin
            lane_diff[l]  = {1'b0, lane_v[l]} - {1'b0, lane_lo[l]};
            lane_dspan[l] = {1'b0, lane_hi[l]} - {1'b0, lane_lo[l]};
            lane_mdiff[l] = lane_diff[l][RAW_W] ? RAW_W'(-lane_diff[l])
                                                : lane_diff[l][RAW_W-1:0];
            lane_mden[l]  = lane_dspan[l][RAW_W] ? RAW_W'(-lane_dspan[l])
                                                 : lane_dspan[l][RAW_W-1:0];
            lane_prod[l]  = PROD_W'(lane_mdiff[l]) * lane_span[l];

            // One restoring step: bring in the next dividend bit and subtract
            // the divisor when it fits.
            lane_trial[l] = {r_rem[l], r_dq[l][PROD_W-1]};
            lane_qbit[l]  = (lane_trial[l] >= {1'b0, r_den[l]});
            lane_sub[l]   = lane_trial[l] - {1'b0, r_den[l]};

            // Signed quotient; a zero span maps the axis to zero.
            if (r_dzero[l]) begin
                lane_q[l] = '0;
            end else if (r_neg[l]) begin
                lane_q[l] = -$signed(MAP_W'(r_dq[l]));
            end else begin
                lane_q[l] = $signed(MAP_W'(r_dq[l]));
            end
        end
    end

    // Edge nudge on screen X, then clamping of both axes.
    always_comb begin
        if (lane_q[0] < K_NUDGE_LO) begin
            x_nudged = lane_q[0] - ((K_NUDGE_LO - lane_q[0]) >>> 2);
        end else if (lane_q[0] > K_NUDGE_HI) begin
            x_nudged = lane_q[0] + ((lane_q[0] - K_NUDGE_HI) >>> 2);
        end else begin
            x_nudged = lane_q[0];
        end

        if (x_nudged[MAP_W-1]) begin
            x_clamped = '0;
        end else if (x_nudged > K_MAX_X) begin
            x_clamped = CX_W'(SCREEN_W - 1);
        end else begin
            x_clamped = x_nudged[CX_W-1:0];
        end

        if (lane_q[1][MAP_W-1]) begin
            y_clamped = '0;
        end else if (lane_q[1] > K_MAX_Y) begin
            y_clamped = CY_W'(SCREEN_H - 1);
        end else begin
            y_clamped = lane_q[1][CY_W-1:0];
        end
    end

    // Manhattan distance from the start point, saturated, and the tap test
    // on release. The hold time wraps with the timestamp.
    always_comb begin
        dist_x    = (r_sx >= r_start_x) ? (r_sx - r_start_x) : (r_start_x - r_sx);
        dist_y    = (r_sy >= r_start_y) ? (r_sy - r_start_y) : (r_start_y - r_sy);
        dist_sum  = DIST_W'(dist_x) + DIST_W'(dist_y);
        dist_sat  = (32'(dist_sum) > 32'(MOVE_SAT)) ? MOVE_W'(MOVE_SAT)
                                                    : MOVE_W'(dist_sum);
        hold_time = r_now - r_down_time;
        tap_ok    = r_active && (r_max_move < r_move_limit)
                    && (hold_time < TIME_W'(r_time_limit));
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = in_touching ? ST_MUL : ST_UPD;
                end
            end
            ST_MUL: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_POST;
                end
            end
            ST_POST: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Register writes; an index past the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_left     <= RST_X_LEFT;
            r_x_right    <= RST_X_RIGHT;
            r_y_top      <= RST_Y_TOP;
            r_y_bottom   <= RST_Y_BOTTOM;
            r_move_limit <= RST_MOVE_LIMIT;
            r_time_limit <= RST_TIME_LIMIT;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_X_LEFT:     r_x_left     <= i_cfg.data[RAW_W-1:0];
                REG_X_RIGHT:    r_x_right    <= i_cfg.data[RAW_W-1:0];
                REG_Y_TOP:      r_y_top      <= i_cfg.data[RAW_W-1:0];
                REG_Y_BOTTOM:   r_y_bottom   <= i_cfg.data[RAW_W-1:0];
                REG_MOVE_LIMIT: r_move_limit <= i_cfg.data[MOVE_W-1:0];
                REG_TIME_LIMIT: r_time_limit <= i_cfg.data[TLIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Datapath: sample capture, divider lanes and the clamped coordinates.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_touch <= in_touching;
            r_raw_x <= i_in.raw_x;
            r_raw_y <= i_in.raw_y;
            r_now   <= i_in.now_ms;
        end
        if (r_state == ST_MUL) begin
            r_cnt <= DIV_CNT_W'(PROD_W - 1);
            for (int l = 0; l < 2; l++) begin
                r_dq[l]    <= lane_prod[l];
                r_rem[l]   <= '0;
                r_den[l]   <= lane_mden[l];
                r_neg[l]   <= lane_diff[l][RAW_W] ^ lane_dspan[l][RAW_W];
                r_dzero[l] <= (lane_dspan[l] == '0);
            end
        end
        if (r_state == ST_DIV) begin
            r_cnt <= r_cnt - 1'b1;
            for (int l = 0; l < 2; l++) begin
                r_dq[l]  <= {r_dq[l][PROD_W-2:0], lane_qbit[l]};
                r_rem[l] <= lane_qbit[l] ? lane_sub[l][RAW_W-1:0]
                                         : lane_trial[l][RAW_W-1:0];
            end
        end
        if (r_state == ST_POST) begin
            r_sx <= x_clamped;
            r_sy <= y_clamped;
        end
    end

    // Touch tracking and the output register. The final step waits until the
    // output register is free, so a result is never overwritten.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_start_x   <= '0;
            r_start_y   <= '0;
            r_max_move  <= '0;
            r_down_time <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_UPD && out_free) begin
                r_out_valid <= 1'b1;
                if (r_touch) begin
                    r_out_x    <= POS_W'(r_sx);
                    r_out_y    <= POS_W'(r_sy);
                    r_out_down <= 1'b1;
                    r_out_tap  <= 1'b0;
                    if (!r_active) begin
                        r_active    <= 1'b1;
                        r_start_x   <= r_sx;
                        r_start_y   <= r_sy;
                        r_max_move  <= '0;
                        r_down_time <= r_now;
                    end else if (dist_sat > r_max_move) begin
                        r_max_move <= dist_sat;
                    end
                end else begin
                    // Release or idle: the start point is reported either way.
                    r_out_x    <= POS_W'(r_start_x);
                    r_out_y    <= POS_W'(r_start_y);
                    r_out_down <= 1'b0;
                    r_out_tap  <= tap_ok;
                    r_active   <= 1'b0;
                end
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.pos_x   = r_out_x;
    assign o_out.pos_y   = r_out_y;
    assign o_out.is_down = r_out_down;
    assign o_out.tap     = r_out_tap;

    `TPTD_ASSERT(a_div_rem_bound, i_clk, i_rst_n, (r_state == ST_DIV && !r_dzero[0]) |-> (r_rem[0] < r_den[0]))
    `TPTD_ASSERT(a_div_exit, i_clk, i_rst_n, (r_state == ST_DIV && r_cnt == '0) |=> (r_state == ST_POST))
    `TPTD_ASSERT(a_release_path, i_clk, i_rst_n, (in_accept && !in_touching) |=> (r_state == ST_UPD))
    `TPTD_NEVER(a_tap_not_down, i_clk, i_rst_n, r_out_valid && r_out_tap && r_out_down)

endmodule

@@ tb/sv/tb_touch_point_and_tap_detector_unit.sv @@
`timescale 1ns / 100ps

module tb_touch_point_and_tap_detector_unit import tptd_pkg::*; ();

    // The register map ends at index 5; these two indexes must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    // One touch-controller sample as it travels on the sample channel.
    typedef struct packed {
        logic              read_ok;
        logic [CNT_W-1:0]  touch_count;
        logic [RAW_W-1:0]  raw_x;
        logic [RAW_W-1:0]  raw_y;
        logic [TIME_W-1:0] now_ms;
    } t_sample;

    // One result as it leaves the block.
    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             is_down;
        logic             tap;
    } t_touch_result;

    // A pending request is either a register write or a sample.
    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_sample               smp;
    } t_req;

    logic i_clk;
    logic i_rst_n;

    tptd_cfg_if cfg_if ();
    tptd_in_if  smp_if ();
    tptd_out_if res_if ();

    touch_point_and_tap_detector_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (smp_if),
        .o_out   (res_if)
    );

    // Calibration and tap limits as the block should hold them.
    logic [RAW_W-1:0]  cal_xl   = RST_X_LEFT;
    logic [RAW_W-1:0]  cal_xr   = RST_X_RIGHT;
    logic [RAW_W-1:0]  cal_yt   = RST_Y_TOP;
    logic [RAW_W-1:0]  cal_yb   = RST_Y_BOTTOM;
    logic [MOVE_W-1:0] lim_move = RST_MOVE_LIMIT;
    logic [TLIM_W-1:0] lim_time = RST_TIME_LIMIT;

    // Gesture tracking state of the block.
    bit                trk_active = 1'b0;
    int                trk_sx     = 0;
    int                trk_sy     = 0;
    int                trk_move   = 0;
    logic [TIME_W-1:0] trk_t0     = '0;

    // Settings the stimulus generator aims at while it builds a phase.
    int gen_cal [4];
    int gen_tlim;

    t_req          req_q [$];
    t_touch_result touch_exp_q [$];

    // Driver state. The sent count is kept with blocking updates so the driver
    // sees its own acceptances at once; the other counters move on edges only.
    t_req            head;
    t_sample         cur_smp   = '0;
    logic [CFG_IDX_W-1:0]  cur_idx  = '0;
    logic [CFG_DATA_W-1:0] cur_data = '0;
    bit              smp_busy  = 1'b0;
    bit              cfg_busy  = 1'b0;
    bit              drv_idle  = 1'b0;
    int              tx_wait   = 0;
    int              tx_burst  = 0;
    int              n_sent    = 0;
    int              n_sent_r  = 0;

    // Monitor state.
    int              n_got     = 0;
    int              n_err     = 0;
    int              rx_hold   = 0;
    int              rx_burst  = 0;
    t_touch_result   got;
    t_touch_result   want;

    // Linear map of one raw axis; a zero span gives zero. SystemVerilog
    // integer division truncates toward zero, which is what the map needs.
    function automatic longint map_axis(longint v, longint lo, longint hi, longint span);
        longint den;
        den = hi - lo;
        if (den == 0)
            return 0;
        return ((v - lo) * span) / den;
    endfunction

    // Works out the result of one accepted sample and advances the tracker.
    function automatic t_touch_result predict_touch(t_sample s);
        t_touch_result res;
        longint x, y;
        int ox, oy, dx, dy, d;
        logic [TIME_W-1:0] held;
        bit touching;
        ox = trk_sx;
        oy = trk_sy;
        res.is_down = 1'b0;
        res.tap = 1'b0;
        touching = s.read_ok && (s.touch_count != 0) &&
                   (s.raw_x <= RAW_LIMIT) && (s.raw_y <= RAW_LIMIT);
        if (touching) begin
            // The axes are swapped: raw Y drives screen X and raw X drives screen Y.
            x = map_axis(s.raw_y, cal_xl, cal_xr, SCREEN_W);
            y = map_axis(s.raw_x, cal_yt, cal_yb, SCREEN_H);
            // Edge nudge on the long axis pushes points toward the borders.
            if (x < NUDGE_LO)
                x = x - (NUDGE_LO - x) / 4;
            else if (x > SCREEN_W - NUDGE_HI_OFS)
                x = x + (x - (SCREEN_W - NUDGE_HI_OFS)) / 4;
            if (x < 0)
                x = 0;
            else if (x > SCREEN_W - 1)
                x = SCREEN_W - 1;
            if (y < 0)
                y = 0;
            else if (y > SCREEN_H - 1)
                y = SCREEN_H - 1;
            ox = int'(x);
            oy = int'(y);
            res.is_down = 1'b1;
            if (!trk_active) begin
                trk_active = 1'b1;
                trk_sx = ox;
                trk_sy = oy;
                trk_move = 0;
                trk_t0 = s.now_ms;
            end else begin
                dx = ox - trk_sx;
                dy = oy - trk_sy;
                d = ((dx < 0) ? -dx : dx) + ((dy < 0) ? -dy : dy);
                if (d > MOVE_SAT)
                    d = MOVE_SAT;
                if (d > trk_move)
                    trk_move = d;
            end
        end else if (trk_active) begin
            trk_active = 1'b0;
            // The hold time wraps with the 32-bit timestamp.
            held = s.now_ms - trk_t0;
            if ((trk_move < lim_move) && (held < lim_time)) begin
                res.tap = 1'b1;
                ox = trk_sx;
                oy = trk_sy;
            end
        end
        res.pos_x = ox[POS_W-1:0];
        res.pos_y = oy[POS_W-1:0];
        return res;
    endfunction

    // Register write as the block should apply it, masked to the register width.
    function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_X_LEFT:     cal_xl = data[RAW_W-1:0];
            REG_X_RIGHT:    cal_xr = data[RAW_W-1:0];
            REG_Y_TOP:      cal_yt = data[RAW_W-1:0];
            REG_Y_BOTTOM:   cal_yb = data[RAW_W-1:0];
            REG_MOVE_LIMIT: lim_move = data[MOVE_W-1:0];
            REG_TIME_LIMIT: lim_time = data[TLIM_W-1:0];
            default: ;
        endcase
    endfunction

    // Sender gap after a request: mostly short, a few long, with gap-free runs.
    function automatic int tx_gap();
        int r;
        if (tx_burst > 0) begin
            tx_burst--;
            return 0;
        end
        if ($urandom_range(0, 59) == 0) begin
            tx_burst = 40;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 25);
        return $urandom_range(30, 150);
    endfunction

    // Receiver stall started at a cycle where it is not stalling already.
    function automatic int rx_pause();
        int r;
        r = $urandom_range(0, 999);
        if (r < 900)
            return 0;
        if (r < 970)
            return $urandom_range(1, 3);
        if (r < 995)
            return $urandom_range(4, 20);
        return $urandom_range(30, 150);
    endfunction

    // Keeps the value bits and fills the bits above the register with noise.
    function automatic logic [CFG_DATA_W-1:0] with_junk(int val, int w);
        logic [CFG_DATA_W-1:0] mask, v;
        mask = CFG_DATA_W'((1 << w) - 1);
        v = CFG_DATA_W'($urandom());
        return (v & ~mask) | (CFG_DATA_W'(val) & mask);
    endfunction

    function automatic int clamp_raw(int v);
        if (v < 0)
            return 0;
        if (v > RAW_LIMIT)
            return RAW_LIMIT;
        return v;
    endfunction

    // A raw coordinate inside the touch range, often at an edge or near a
    // calibration endpoint, where the map and the nudge change behavior.
    function automatic int pick_raw();
        int r, d;
        r = $urandom_range(0, 9);
        d = $urandom_range(0, 4);
        case (r)
            0: return 0;
            1: return RAW_LIMIT;
            2, 3: return clamp_raw(gen_cal[$urandom_range(0, 3)] + d - 2);
            default: return $urandom_range(0, RAW_LIMIT);
        endcase
    endfunction

    // Finger movement between two samples of one touch.
    function automatic int jitter(int v);
        int r, d;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            d = $urandom_range(0, 6);
            return clamp_raw(v + d - 3);
        end
        if (r < 9) begin
            d = $urandom_range(0, 40);
            return clamp_raw(v + d - 20);
        end
        return $urandom_range(0, RAW_LIMIT);
    endfunction

    task automatic add_smp(logic ok, logic [CNT_W-1:0] cnt, logic [RAW_W-1:0] rx,
                           logic [RAW_W-1:0] ry, logic [TIME_W-1:0] now);
        t_req e;
        e = '0;
        e.smp.read_ok = ok;
        e.smp.touch_count = cnt;
        e.smp.raw_x = rx;
        e.smp.raw_y = ry;
        e.smp.now_ms = now;
        req_q.push_back(e);
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_req e;
        e = '0;
        e.is_cfg = 1'b1;
        e.idx = idx;
        e.data = data;
        req_q.push_back(e);
    endtask

    // Queues a write of every register and notes the values for the generator.
    task automatic set_regs(int xl, int xr, int yt, int yb, int mv, int tl);
        add_cfg(REG_X_LEFT, with_junk(xl, RAW_W));
        add_cfg(REG_X_RIGHT, with_junk(xr, RAW_W));
        add_cfg(REG_Y_TOP, with_junk(yt, RAW_W));
        add_cfg(REG_Y_BOTTOM, with_junk(yb, RAW_W));
        add_cfg(REG_MOVE_LIMIT, with_junk(mv, MOVE_W));
        add_cfg(REG_TIME_LIMIT, with_junk(tl, TLIM_W));
        gen_cal[0] = xl;
        gen_cal[1] = xr;
        gen_cal[2] = yt;
        gen_cal[3] = yb;
        gen_tlim = tl;
    endtask

    // A complete touch: press, some movement, then one of the ways a touch
    // ends. The release time is often placed right at the hold limit.
    task automatic add_gesture();
        logic [TIME_W-1:0] t, t0;
        int x, y, n, k;
        t = $urandom();
        t0 = t;
        x = pick_raw();
        y = pick_raw();
        add_smp(1'b1, CNT_W'($urandom_range(1, 15)), RAW_W'(x), RAW_W'(y), t);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 15) : $urandom_range(0, 5);
        for (k = 0; k < n; k++) begin
            x = jitter(x);
            y = jitter(y);
            t = t + $urandom_range(0, 40);
            add_smp(1'b1, CNT_W'($urandom_range(1, 15)), RAW_W'(x), RAW_W'(y), t);
        end
        case ($urandom_range(0, 9))
            0, 1, 2: t = t0 + gen_tlim - 1;
            3:       t = t0 + gen_tlim;
            4:       t = t + $urandom();
            default: t = t + $urandom_range(0, 200);
        endcase
        case ($urandom_range(0, 3))
            0: add_smp(1'b0, CNT_W'($urandom()), RAW_W'($urandom()), RAW_W'($urandom()), t);
            1: add_smp(1'b1, '0, RAW_W'(x), RAW_W'(y), t);
            2: add_smp(1'b1, CNT_W'($urandom_range(1, 15)),
                       RAW_W'($urandom_range(RAW_LIMIT + 1, 4095)), RAW_W'(y), t);
            default: add_smp(1'b1, CNT_W'($urandom_range(1, 15)), RAW_W'(x),
                             RAW_W'($urandom_range(RAW_LIMIT + 1, 4095)), t);
        endcase
    endtask

    // Mostly well-formed touches with random content, the rest pure noise.
    task automatic add_phase(int count);
        int stop;
        stop = req_q.size() + count;
        while (req_q.size() < stop) begin
            if ($urandom_range(0, 99) < 80)
                add_gesture();
            else
                add_smp(1'($urandom()), CNT_W'($urandom()), RAW_W'($urandom()),
                        RAW_W'($urandom()), TIME_W'($urandom()));
        end
    endtask

    // Clock: 12 ns period.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Sender side. Each request stays up until it is taken. A register write
    // is only issued once every result of the samples before it has been
    // taken, so the block is idle when its settings change.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (smp_busy && smp_if.ready) begin
                touch_exp_q.push_back(predict_touch(cur_smp));
                n_sent++;
                smp_busy = 1'b0;
                tx_wait = tx_gap();
            end
            if (cfg_busy && cfg_if.ready) begin
                write_reg(cur_idx, cur_data);
                cfg_busy = 1'b0;
            end
            if (!smp_busy && !cfg_busy && (req_q.size() != 0)) begin
                if (req_q[0].is_cfg) begin
                    if (n_sent == n_got) begin
                        head = req_q.pop_front();
                        cur_idx = head.idx;
                        cur_data = head.data;
                        cfg_busy = 1'b1;
                    end
                end else if (tx_wait != 0) begin
                    tx_wait--;
                end else begin
                    head = req_q.pop_front();
                    cur_smp = head.smp;
                    smp_busy = 1'b1;
                end
            end
            smp_if.valid       <= smp_busy;
            smp_if.read_ok     <= cur_smp.read_ok;
            smp_if.touch_count <= cur_smp.touch_count;
            smp_if.raw_x       <= cur_smp.raw_x;
            smp_if.raw_y       <= cur_smp.raw_y;
            smp_if.now_ms      <= cur_smp.now_ms;
            cfg_if.valid       <= cfg_busy;
            cfg_if.index       <= cur_idx;
            cfg_if.data        <= cur_data;
            drv_idle           <= !smp_busy && !cfg_busy && (req_q.size() == 0);
            n_sent_r           <= n_sent;
        end
    end

    // Receiver side. Every taken result is checked against the oldest
    // expectation, and ready is stalled at random with long gap-free runs.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got = {res_if.pos_x, res_if.pos_y, res_if.is_down, res_if.tap};
                n_got <= n_got + 1;
                if (touch_exp_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected result: pos_x=%0d pos_y=%0d is_down=%0b tap=%0b",
                                 got.pos_x, got.pos_y, got.is_down, got.tap);
                end else begin
                    want = touch_exp_q.pop_front();
                    if ((got.pos_x !== want.pos_x) || (got.pos_y !== want.pos_y) ||
                        (got.is_down !== want.is_down) || (got.tap !== want.tap)) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("mismatch: expected %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
                                     want.pos_x, want.pos_y, want.is_down, want.tap,
                                     got.pos_x, got.pos_y, got.is_down, got.tap);
                    end
                end
            end
            if (rx_burst != 0) begin
                rx_burst--;
                rx_hold = 0;
            end else if (rx_hold != 0) begin
                rx_hold--;
            end else begin
                rx_hold = rx_pause();
                if ($urandom_range(0, 499) == 0)
                    rx_burst = 200;
            end
            res_if.ready <= (rx_hold == 0);
        end
    end

    // Stimulus, reset and the end of the run.
    initial begin
        i_rst_n            = 1'b0;
        smp_if.valid       = 1'b0;
        smp_if.read_ok     = 1'b0;
        smp_if.touch_count = '0;
        smp_if.raw_x       = '0;
        smp_if.raw_y       = '0;
        smp_if.now_ms      = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        res_if.ready       = 1'b0;

        gen_cal[0] = RST_X_LEFT;
        gen_cal[1] = RST_X_RIGHT;
        gen_cal[2] = RST_Y_TOP;
        gen_cal[3] = RST_Y_BOTTOM;
        gen_tlim = RST_TIME_LIMIT;

        // Directed samples under the reset settings. Each non-touch reason on
        // its own, then touches at the corners where the nudge and the clamp
        // act, a release that moved too far, a hold across the timestamp wrap,
        // and holds one below and exactly at the time limit.
        add_smp(1'b0, 4'd0, 12'd0, 12'd0, 32'd0);
        add_smp(1'b1, 4'd0, 12'd100, 12'd100, 32'd1);
        add_smp(1'b0, 4'd5, 12'd100, 12'd100, 32'd2);
        add_smp(1'b1, 4'd1, 12'd801, 12'd100, 32'd3);
        add_smp(1'b1, 4'd1, 12'd100, 12'd801, 32'd4);
        add_smp(1'b1, 4'd15, 12'd4095, 12'd4095, 32'd5);
        add_smp(1'b1, 4'd1, 12'd800, 12'd800, 32'd10);
        add_smp(1'b1, 4'd2, 12'd800, 12'd800, 32'd20);
        add_smp(1'b0, 4'd1, 12'd800, 12'd800, 32'd30);
        add_smp(1'b1, 4'd1, 12'd10, 12'd289, 32'd100);
        add_smp(1'b1, 4'd1, 12'd227, 12'd8, 32'd200);
        add_smp(1'b1, 4'd0, 12'd0, 12'd0, 32'd300);
        add_smp(1'b1, 4'd1, 12'd0, 12'd0, 32'hFFFF_FF00);
        add_smp(1'b0, 4'd0, 12'd0, 12'd0, 32'h0000_0010);
        add_smp(1'b1, 4'd3, 12'd120, 12'd150, 32'd1000);
        add_smp(1'b1, 4'd3, 12'd120, 12'd150, 32'd1699);
        add_smp(1'b0, 4'd3, 12'd120, 12'd150, 32'd1700);
        add_smp(1'b1, 4'd3, 12'd120, 12'd150, 32'd2000);
        add_smp(1'b1, 4'd0, 12'd0, 12'd0, 32'd2699);
        add_smp(1'b1, 4'd8, 12'd50, 12'd50, 32'hFFFF_FFFF);
        add_smp(1'b0, 4'd8, 12'd50, 12'd50, 32'd0);
        add_smp(1'b1, 4'd1, 12'd116, 12'd150, 32'd5000);
        add_smp(1'b1, 4'd1, 12'd140, 12'd120, 32'd5010);
        add_smp(1'b1, 4'd0, 12'd0, 12'd0, 32'd5020);

        add_phase(200);

        // Full-range calibration with the widest limits; writes past the
        // register map must change nothing.
        set_regs(0, 4095, 0, 4095, 1023, 65535);
        add_cfg(REG_SPARE_A, CFG_DATA_W'($urandom()));
        add_cfg(REG_SPARE_B, CFG_DATA_W'($urandom()));
        add_phase(230);

        // Zero spans on both axes and zero limits, so no tap can qualify.
        set_regs(300, 300, 0, 0, 0, 0);
        add_phase(230);

        set_regs(800, 0, 0, 800, 40, 300);
        add_phase(230);

        // Very steep maps throw most points far past the screen edges.
        set_regs(400, 401, 400, 402, 1023, 65535);
        add_phase(230);

        set_regs(0, 800, 800, 0, 1, 1);
        add_cfg(REG_SPARE_B, 16'hFFFF);
        add_phase(230);

        set_regs($urandom_range(0, 800), $urandom_range(0, 800), $urandom_range(0, 800),
                 $urandom_range(0, 800), $urandom_range(0, 1023), $urandom_range(0, 2000));
        add_phase(230);

        set_regs(4095, 0, 4095, 0, 0, 65535);
        add_phase(100);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request has gone out and every result came back,
        // then give the block time to show any stray result.
        do
            @(posedge i_clk);
        while (!(drv_idle && (n_sent_r == n_got)));
        repeat (60) @(posedge i_clk);
        if (touch_exp_q.size() != 0)
            n_err++;

        if (n_err == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #30000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
